FILE: sv/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is high.
`define B64X_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication check, disabled while reset is high.
`define B64X_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check, disabled while reset is high.
`define B64X_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/b64x_pkg.sv
// Types, constants and the character lookup of the Base64 decoder.
// No dependencies; used by the interfaces and every decoder module.
`default_nettype none

package b64x_pkg;

   localparam int CHAR_W   = 8;
   localparam int SEXTET_W = 6;
   localparam int BYTE_W   = 8;
   localparam int BITS_W   = 18;   // first three sextets of a group
   localparam int GROUP_W  = 24;   // three bytes
   localparam int CNT_W    = 2;

   localparam logic [CNT_W-1:0]  CNT_FULL   = 2'd3;
   localparam logic [CNT_W-1:0]  CNT_ONE    = 2'd1;
   localparam logic [CNT_W-1:0]  POS_THIRD  = 2'd2;
   localparam logic [BYTE_W-1:0] KEY_RESET  = 8'hFB;

   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D;

   // offsets that move each character range onto its sextet value
   localparam logic [CHAR_W-1:0] OFS_LOWER  = 8'h47;  // 'a' - 26
   localparam logic [CHAR_W-1:0] OFS_DIGIT  = 8'h04;  // 52 - '0', added

   localparam logic [SEXTET_W-1:0] SX_PLUS  = 6'd62;
   localparam logic [SEXTET_W-1:0] SX_SLASH = 6'd63;

   typedef struct packed {
      logic                ok;
      logic [SEXTET_W-1:0] val;
   } sextet_type;

   // One finished group, handed from the assembler to the serializer.
   typedef struct packed {
      logic [GROUP_W-1:0] bytes;      // keyed bytes, first byte in the top
      logic [CNT_W-1:0]   count;      // bytes to send, 1..3
      logic               final_grp;  // last beat carries final_byte
      logic               bad;        // error result
   } rec_type;

   function automatic sextet_type sextet_lookup(input logic [CHAR_W-1:0] c);
      sextet_type         r;
      logic [CHAR_W-1:0]  t;
      r = '{ok: 1'b1, val: '0};
      t = '0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         t     = c - CH_UPPER_A;
         r.val = t[SEXTET_W-1:0];
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         t     = c - OFS_LOWER;
         r.val = t[SEXTET_W-1:0];
      end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         t     = c + OFS_DIGIT;
         r.val = t[SEXTET_W-1:0];
      end else if (c == CH_PLUS) begin
         r.val = SX_PLUS;
      end else if (c == CH_SLASH) begin
         r.val = SX_SLASH;
      end else if (c == CH_PAD) begin
         r.val = '0;
      end else begin
         r.ok  = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/b64x_if.sv
// Valid/ready channel interfaces for characters in and bytes out.
// Depends on b64x_pkg for field widths.
`default_nettype none

interface b64x_req_if;
   logic                        valid;
   logic                        ready;
   logic [b64x_pkg::CHAR_W-1:0] code_char;
   logic                        final_char;

   modport source (output valid, output code_char, output final_char, input ready);
   modport sink   (input valid, input code_char, input final_char, output ready);
endinterface

interface b64x_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [b64x_pkg::BYTE_W-1:0] plain_byte;
   logic                        final_byte;
   logic                        bad_input;

   modport source (output valid, output plain_byte, output final_byte, output bad_input,
                   input ready);
   modport sink   (input valid, input plain_byte, input final_byte, input bad_input,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/b64x_group.sv
// Group assembler: decodes one character per beat and builds group records.
// Depends on b64x_pkg, b64x_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module b64x_group (
   input  wire                          clock,
   input  wire                          reset,
   b64x_req_if.sink                     req_chan,
   input  wire  [b64x_pkg::BYTE_W-1:0]  key,
   input  wire                          rec_take,
   output logic                         rec_valid,
   output b64x_pkg::rec_type            rec
);
   import b64x_pkg::*;

   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              third_ff, third_in;
   logic              err_ff, err_in;
   logic              rec_valid_ff, rec_valid_in;
   rec_type           rec_ff, rec_in;

   sextet_type        sx;
   logic              pad;
   logic              fire;
   logic [GROUP_W-1:0] word;
   logic [CNT_W-1:0]  cnt;

   assign req_chan.ready = !rec_valid_ff || rec_take;
   assign rec_valid      = rec_valid_ff;
   assign rec            = rec_ff;

   always_comb begin
      sx   = sextet_lookup(req_chan.code_char);
      pad  = (req_chan.code_char == CH_PAD);
      fire = req_chan.valid && req_chan.ready;
      word = {bits_ff, sx.val};
      cnt  = CNT_FULL - {1'b0, req_chan.final_char && pad}
                      - {1'b0, req_chan.final_char && third_ff};

      bits_in      = bits_ff;
      pos_in       = pos_ff;
      third_in     = third_ff;
      err_in       = err_ff;
      rec_in       = rec_ff;
      rec_valid_in = rec_valid_ff && !rec_take;

      if (fire) begin
         if (err_ff || !sx.ok) begin
            // sticky error: drop until the final char, then one error beat
            if (req_chan.final_char) begin
               rec_in       = '{bytes: '0, count: CNT_ONE, final_grp: 1'b1, bad: 1'b1};
               rec_valid_in = 1'b1;
               bits_in      = '0;
               pos_in       = '0;
               third_in     = 1'b0;
               err_in       = 1'b0;
            end else begin
               err_in       = 1'b1;
            end
         end else if (pos_ff != CNT_FULL) begin
            if (pos_ff == POS_THIRD) begin
               third_in = pad;
            end
            bits_in = {bits_ff[BITS_W-SEXTET_W-1:0], sx.val};
            pos_in  = pos_ff + CNT_ONE;
            if (req_chan.final_char) begin
               // short final group
               rec_in       = '{bytes: '0, count: CNT_ONE, final_grp: 1'b1, bad: 1'b1};
               rec_valid_in = 1'b1;
               bits_in      = '0;
               pos_in       = '0;
               third_in     = 1'b0;
            end
         end else begin
            rec_in.bytes     = word ^ {3{key}};
            rec_in.count     = cnt;
            rec_in.final_grp = req_chan.final_char;
            rec_in.bad       = 1'b0;
            rec_valid_in     = 1'b1;
            bits_in          = '0;
            pos_in           = '0;
            third_in         = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff      <= '0;
         pos_ff       <= '0;
         third_ff     <= 1'b0;
         err_ff       <= 1'b0;
         rec_valid_ff <= 1'b0;
      end else begin
         bits_ff      <= bits_in;
         pos_ff       <= pos_in;
         third_ff     <= third_in;
         err_ff       <= err_in;
         rec_valid_ff <= rec_valid_in;
      end
      rec_ff <= rec_in;
   end

   `B64X_ASSERT_NXT(a_rec_held, clock, reset, rec_valid_ff && !rec_take,
      rec_valid_ff && $stable(rec_ff), "pending group record lost or changed")
   `B64X_ASSERT_IMP(a_err_rec, clock, reset, rec_valid_ff && rec_ff.bad,
      rec_ff.final_grp && rec_ff.count == CNT_ONE && rec_ff.bytes == '0,
      "error record malformed")
   `B64X_ASSERT_IMP(a_mid_full, clock, reset, rec_valid_ff && !rec_ff.final_grp,
      rec_ff.count == CNT_FULL, "non-final group not three bytes")

endmodule

`default_nettype wire

FILE: sv/b64x_emit.sv
// Byte serializer: sends the bytes of one group record, one per beat.
// Depends on b64x_pkg, b64x_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module b64x_emit (
   input  wire                clock,
   input  wire                reset,
   input  wire                rec_valid,
   input  b64x_pkg::rec_type  rec,
   output logic               rec_take,
   b64x_rsp_if.source         rsp_chan
);
   import b64x_pkg::*;

   logic [GROUP_W-1:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               final_ff, final_in;
   logic               bad_ff, bad_in;
   logic               out_valid_ff, out_valid_in;
   logic               fire;

   assign fire     = out_valid_ff && rsp_chan.ready;
   assign rec_take = rec_valid && (!out_valid_ff || (fire && left_ff == CNT_ONE));

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.plain_byte = bytes_ff[GROUP_W-1 -: BYTE_W];
   assign rsp_chan.final_byte = final_ff && (left_ff == CNT_ONE);
   assign rsp_chan.bad_input  = bad_ff;

   always_comb begin
      bytes_in     = bytes_ff;
      left_in      = left_ff;
      final_in     = final_ff;
      bad_in       = bad_ff;
      out_valid_in = out_valid_ff;
      if (rec_take) begin
         bytes_in     = rec.bytes;
         left_in      = rec.count;
         final_in     = rec.final_grp;
         bad_in       = rec.bad;
         out_valid_in = 1'b1;
      end else if (fire) begin
         bytes_in = {bytes_ff[GROUP_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
         left_in  = left_ff - CNT_ONE;
         if (left_ff == CNT_ONE) begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
      end
      bytes_ff <= bytes_in;
      final_ff <= final_in;
      bad_ff   <= bad_in;
   end

   `B64X_ASSERT_IMP(a_left_nz, clock, reset, out_valid_ff, left_ff != '0,
      "valid output with no bytes left")
   `B64X_ASSERT_IMP(a_bad_single, clock, reset, out_valid_ff && bad_ff,
      left_ff == CNT_ONE && final_ff, "error beat not single and final")
   `B64X_ASSERT_NXT(a_step, clock, reset, fire && left_ff != CNT_ONE,
      out_valid_ff && left_ff == $past(left_ff) - CNT_ONE, "byte count skipped")

endmodule

`default_nettype wire

FILE: sv/base64_decode_xor.sv
// Base64 decoder with XOR descrambling: one char per cycle in, one byte per beat out.
// A group's 4th char is registered into the group record, then its first byte into the output register.
// Throughput: 1 char/cycle sustained; a group needs 1..3 output beats, 4 input beats.
// Input stalls only while a finished record waits behind a busy serializer.
// Reset (synchronous, active high): empties group and output stages, key = 0xFB.
// Depends on b64x_pkg, b64x_if, b64x_group and b64x_emit.
`default_nettype none

module base64_decode_xor (
   input  wire                          clock,
   input  wire                          reset,
   b64x_req_if.sink                     req_chan,
   b64x_rsp_if.source                   rsp_chan,
   input  wire                          csr_we,
   input  wire  [b64x_pkg::BYTE_W-1:0]  csr_wdata
);
   import b64x_pkg::*;

   // descramble key; the user must write it only while idle, the block does not enforce this
   logic [BYTE_W-1:0] key_ff, key_in;

   // record handoff between assembler and serializer
   logic    rec_valid;
   logic    rec_take;
   rec_type rec;

   assign key_in = csr_we ? csr_wdata : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   // Assembler: maps chars to sextets, tracks padding and the sticky error,
   // and drops one record per finished group or error into its output register.
   b64x_group u_group (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .key       (key_ff),
      .rec_take  (rec_take),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   // Serializer: sends the record bytes one beat at a time, and takes the
   // next record in the same cycle its last beat goes out.
   b64x_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec       (rec),
      .rec_take  (rec_take),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
